FILE: src/sbct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbct_pkg
// Types and constants shared by the swept box collision table modules.
// ----------------------------------------------------------------------------
package sbct_pkg;

    localparam int C_W  = 32;   // centre / target coordinate
    localparam int E_W  = 31;   // half extent
    localparam int B_W  = 33;   // box bound (centre +/- extent)
    localparam int N_W  = 34;   // division numerator and velocity
    localparam int T_W  = 17;   // contact time q1.16
    localparam int Q_W  = 18;   // signed divider quotient
    localparam int D_W  = 33;   // sweep displacement
    localparam int P_W  = 51;   // displacement times time
    localparam int K_W  = 37;   // contact box bounds
    localparam int BIAS_W = 16;

    localparam logic [T_W-1:0] ONE_Q16     = 17'd65536;
    localparam logic [T_W-1:0] NO_HIT_TIME = 17'd66191;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_OVERLAP = 2'd2,
        OP_SWEEP   = 2'd3
    } op_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [2:0] NRM_UP         = 3'd0;
    localparam logic [2:0] NRM_DOWN       = 3'd1;
    localparam logic [2:0] NRM_LEFT       = 3'd2;
    localparam logic [2:0] NRM_RIGHT      = 3'd3;
    localparam logic [2:0] NRM_LEFT_MINY  = 3'd4;
    localparam logic [2:0] NRM_LEFT_PLUSY = 3'd5;
    localparam logic [2:0] NRM_RIGHT_MINY = 3'd6;
    localparam logic [2:0] NRM_RIGHT_PLUSY = 3'd7;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_RD,
        BK_EV,
        BK_DIV,
        BK_MUL,
        BK_NORM,
        BK_LAST_RD,
        BK_LAST_EV,
        BK_RESULT
    } bk_state_t;

    typedef struct packed {
        logic [E_W-1:0]        ey;
        logic [E_W-1:0]        ex;
        logic signed [C_W-1:0] cy;
        logic signed [C_W-1:0] cx;
    } entry_t;

    typedef struct packed {
        op_t                   op;
        logic signed [C_W-1:0] ty;
        logic signed [C_W-1:0] tx;
        entry_t                box;
    } item_t;

    typedef struct packed {
        logic           valid;
        item_t          item;
    } head_t;

    typedef struct packed {
        logic [2:0]     normal_code;
        logic [T_W-1:0] last_contact;
        logic [T_W-1:0] first_contact;
        logic           hit;
        logic [1:0]     status;
    } result_t;

endpackage

FILE: src/sbct_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbct_ram
// Generic single write port, single read port ram with registered read.
// ----------------------------------------------------------------------------
module sbct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                    aclk,
    input  wire logic                    we,
    input  wire logic [AW-1:0]           waddr,
    input  wire logic [WIDTH-1:0]        wdata,
    input  wire logic [AW-1:0]           raddr,
    output logic      [WIDTH-1:0]        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: src/sbct_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbct_front
// Input side: decodes the command of each transfer and holds up to two
// decoded items for the back end.
// ----------------------------------------------------------------------------
module sbct_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [1:0]       in_cmd,
    input  wire sbct_pkg::entry_t in_box,
    input  wire logic signed [sbct_pkg::C_W-1:0] in_tx,
    input  wire logic signed [sbct_pkg::C_W-1:0] in_ty,
    output sbct_pkg::head_t       head,
    input  wire logic             pop
);
    sbct_pkg::item_t slot_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      fill_reg, fill_next;
    sbct_pkg::item_t dec;
    logic            push;

    always_comb begin
        dec.box = in_box;
        dec.tx  = in_tx;
        dec.ty  = in_ty;
        unique case (in_cmd)
            2'd0:    dec.op = sbct_pkg::OP_ADD;
            2'd1:    dec.op = sbct_pkg::OP_REMOVE;
            2'd2:    dec.op = sbct_pkg::OP_OVERLAP;
            default: dec.op = sbct_pkg::OP_SWEEP;
        endcase
    end

    assign in_ready   = (fill_reg != 2'd2);
    assign push       = in_valid && in_ready;
    assign head.valid = (fill_reg != 2'd0);
    assign head.item  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ (pop && head.valid);
        fill_next   = fill_reg + 2'(push) - 2'(pop && head.valid);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= dec;
        end
    end
endmodule
`default_nettype wire

FILE: src/sbct_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbct_div
// Serial divider: floor(num * 65536 / den) clamped to +/- 1.0 in q16,
// rounding toward minus infinity, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sbct_div (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic signed [sbct_pkg::N_W-1:0]   num,
    input  wire logic signed [sbct_pkg::N_W-1:0]   den,
    output logic                                   busy,
    output logic signed [sbct_pkg::Q_W-1:0]        quot
);
    localparam int N_W = sbct_pkg::N_W;
    localparam int T_W = sbct_pkg::T_W;
    localparam int Q_W = sbct_pkg::Q_W;

    logic             busy_reg, busy_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic [N_W:0]     rem_reg, rem_next;
    logic [N_W-1:0]   ad_reg, ad_next;
    logic [T_W-1:0]   q_reg, q_next;
    logic             neg_reg, neg_next;
    logic             nz_reg, nz_next;
    logic             sat_reg, sat_next;

    logic [N_W-1:0]   an, ad;
    logic             ge;
    logic [N_W:0]     r;
    logic [Q_W-1:0]   mag;

    always_comb begin
        an = num[N_W-1] ? N_W'(-num) : N_W'(num);
        ad = den[N_W-1] ? N_W'(-den) : N_W'(den);
        ge = (rem_reg >= {1'b0, ad_reg});
        r  = ge ? (rem_reg - {1'b0, ad_reg}) : rem_reg;

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        ad_next   = ad_reg;
        q_next    = q_reg;
        neg_next  = neg_reg;
        nz_next   = nz_reg;
        sat_next  = sat_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 5'd16;
            rem_next  = {1'b0, an};
            ad_next   = ad;
            neg_next  = num[N_W-1] ^ den[N_W-1];
            nz_next   = (an != '0);
            sat_next  = ({1'b0, an} >= {ad, 1'b0});
        end else if (busy_reg) begin
            q_next   = {q_reg[T_W-2:0], ge};
            rem_next = {r[N_W-1:0], 1'b0};
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    always_comb begin
        if (sat_reg) begin
            mag = Q_W'(sbct_pkg::ONE_Q16);
        end else begin
            mag = {1'b0, q_reg} + Q_W'(neg_reg && nz_reg && (rem_reg != '0));
        end
        if (mag > Q_W'(sbct_pkg::ONE_Q16)) begin
            mag = Q_W'(sbct_pkg::ONE_Q16);
        end
        quot = (neg_reg && nz_reg) ? -$signed(mag) : $signed(mag);
    end

    assign busy = busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        ad_reg  <= ad_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
        nz_reg  <= nz_next;
        sat_reg <= sat_next;
    end
endmodule
`default_nettype wire

FILE: src/sbct_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbct_back
// Command engine: walks the box table one entry at a time, runs the
// per-axis dividers for sweeps and holds the result register.
// ----------------------------------------------------------------------------
module sbct_back #(
    parameter int MAX_BOXES = 64
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire sbct_pkg::head_t                 head,
    output logic                                 pop,
    input  wire logic [sbct_pkg::BIAS_W-1:0]     bias,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output sbct_pkg::result_t                    out_res
);
    localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam int B_W = sbct_pkg::B_W;
    localparam int N_W = sbct_pkg::N_W;
    localparam int T_W = sbct_pkg::T_W;
    localparam int Q_W = sbct_pkg::Q_W;
    localparam int D_W = sbct_pkg::D_W;
    localparam int P_W = sbct_pkg::P_W;
    localparam int K_W = sbct_pkg::K_W;

    sbct_pkg::bk_state_t state_reg, state_next;
    sbct_pkg::item_t     cur_reg, cur_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    found_reg, found_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    logic signed [B_W-1:0] smin_reg [2], smin_next [2];
    logic signed [B_W-1:0] smax_reg [2], smax_next [2];
    logic signed [N_W-1:0] vel_reg [2], vel_next [2];
    logic signed [D_W-1:0] dlt_reg [2], dlt_next [2];
    logic signed [B_W-1:0] bmin_reg [2], bmin_next [2];
    logic signed [B_W-1:0] bmax_reg [2], bmax_next [2];
    logic                  ca_reg [2], ca_next [2];
    logic                  cb_reg [2], cb_next [2];
    logic [T_W-1:0]        fc_reg, fc_next;
    logic [T_W-1:0]        lc_reg, lc_next;
    logic signed [P_W-1:0] prod_reg [2], prod_next [2];

    logic [1:0]      status_reg, status_next;
    logic            hit_reg, hit_next;
    logic [T_W-1:0]  best_reg, best_next;
    logic [T_W-1:0]  last_reg, last_next;
    logic [2:0]      normal_reg, normal_next;

    logic              out_valid_reg, out_valid_next;
    sbct_pkg::result_t out_res_reg, out_res_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr, ram_raddr, last_idx;
    sbct_pkg::entry_t     ram_wdata, ram_rdata;

    logic                  div_start;
    logic signed [N_W-1:0] div_num [2];
    logic                  div_busy [2];
    logic signed [Q_W-1:0] div_q [2];

    logic signed [B_W-1:0] eb_min [2], eb_max [2];
    logic                  ov;
    logic                  is_end;
    logic signed [Q_W-1:0] u0 [2], u1 [2], first_s, last_s;
    logic signed [K_W-1:0] cc [2], kmin [2], kmax [2], bmn [2], bmx [2];
    logic [2:0]            nrm;
    logic                  out_free;

    assign last_idx  = IDX_W'(count_reg - CNT_W'(1));
    assign ram_raddr = (state_reg == sbct_pkg::BK_LAST_RD) ? last_idx : idx_reg;
    assign is_end    = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign out_free  = !out_valid_reg || out_ready;

    sbct_ram #(
        .WIDTH ($bits(sbct_pkg::entry_t)),
        .DEPTH (MAX_BOXES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    for (genvar a = 0; a < 2; a++) begin : g_div
        sbct_div u_div (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (div_start),
            .num     (div_num[a]),
            .den     (vel_reg[a]),
            .busy    (div_busy[a]),
            .quot    (div_q[a])
        );
    end

    // table entry bounds and start overlap
    always_comb begin
        eb_min[0] = B_W'(ram_rdata.cx) - $signed(B_W'(ram_rdata.ex));
        eb_max[0] = B_W'(ram_rdata.cx) + $signed(B_W'(ram_rdata.ex));
        eb_min[1] = B_W'(ram_rdata.cy) - $signed(B_W'(ram_rdata.ey));
        eb_max[1] = B_W'(ram_rdata.cy) + $signed(B_W'(ram_rdata.ey));
        ov = (smin_reg[0] < eb_max[0]) && (eb_min[0] < smax_reg[0]) &&
             (smin_reg[1] < eb_max[1]) && (eb_min[1] < smax_reg[1]);
        for (int a = 0; a < 2; a++) begin
            div_num[a] = ca_next[a] ? (N_W'(eb_min[a]) - N_W'(smax_reg[a]))
                                    : (N_W'(eb_max[a]) - N_W'(smin_reg[a]));
        end
    end

    // entry and exit times, contact position and normal
    always_comb begin
        logic vpos, vneg;
        for (int a = 0; a < 2; a++) begin
            vpos  = !vel_reg[a][N_W-1] && (vel_reg[a] != '0);
            vneg  = vel_reg[a][N_W-1];
            u0[a] = ((ca_reg[a] && vpos) || (cb_reg[a] && vneg)) ? div_q[a] : '0;
            u1[a] = ((cb_reg[a] && vpos) || (ca_reg[a] && vneg)) ? div_q[a]
                                                                 : $signed(Q_W'(sbct_pkg::ONE_Q16));
            cc[a]   = K_W'(a == 0 ? cur_reg.box.cx : cur_reg.box.cy) + K_W'(prod_reg[a] >>> 16);
            kmin[a] = cc[a] - $signed(K_W'(a == 0 ? cur_reg.box.ex : cur_reg.box.ey));
            kmax[a] = cc[a] + $signed(K_W'(a == 0 ? cur_reg.box.ex : cur_reg.box.ey));
            bmn[a]  = K_W'(bmin_reg[a]);
            bmx[a]  = K_W'(bmax_reg[a]);
        end
        first_s = (u0[0] > u0[1]) ? u0[0] : u0[1];
        last_s  = (u1[0] < u1[1]) ? u1[0] : u1[1];
        priority if (kmax[0] <= bmn[0]) begin
            nrm = (kmax[1] < bmn[1]) ? sbct_pkg::NRM_LEFT_MINY :
                  (kmin[1] > bmx[1]) ? sbct_pkg::NRM_LEFT_PLUSY : sbct_pkg::NRM_LEFT;
        end else if (kmin[0] >= bmx[0]) begin
            nrm = (kmax[1] < bmn[1]) ? sbct_pkg::NRM_RIGHT_MINY :
                  (kmin[1] > bmx[1]) ? sbct_pkg::NRM_RIGHT_PLUSY : sbct_pkg::NRM_RIGHT;
        end else begin
            nrm = (kmax[1] <= bmn[1]) ? sbct_pkg::NRM_UP : sbct_pkg::NRM_DOWN;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        count_next     = count_reg;
        fc_next        = fc_reg;
        lc_next        = lc_reg;
        status_next    = status_reg;
        hit_next       = hit_reg;
        best_next      = best_reg;
        last_next      = last_reg;
        normal_next    = normal_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_res_next   = out_res_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = found_reg;
        ram_wdata      = ram_rdata;
        div_start      = 1'b0;
        for (int a = 0; a < 2; a++) begin
            smin_next[a] = smin_reg[a];
            smax_next[a] = smax_reg[a];
            vel_next[a]  = vel_reg[a];
            dlt_next[a]  = dlt_reg[a];
            bmin_next[a] = bmin_reg[a];
            bmax_next[a] = bmax_reg[a];
            ca_next[a]   = smax_reg[a] <= eb_min[a];
            cb_next[a]   = eb_max[a] <= smin_reg[a];
            prod_next[a] = dlt_reg[a] * $signed({1'b0, fc_reg});
        end

        unique case (state_reg)
            sbct_pkg::BK_IDLE: begin
                if (head.valid) begin
                    pop         = 1'b1;
                    cur_next    = head.item;
                    idx_next    = '0;
                    status_next = sbct_pkg::ST_OK;
                    hit_next    = 1'b0;
                    last_next   = '0;
                    normal_next = sbct_pkg::NRM_UP;
                    best_next   = (head.item.op == sbct_pkg::OP_SWEEP) ? sbct_pkg::NO_HIT_TIME
                                                                        : '0;
                    smin_next[0] = B_W'(head.item.box.cx) - $signed(B_W'(head.item.box.ex));
                    smax_next[0] = B_W'(head.item.box.cx) + $signed(B_W'(head.item.box.ex));
                    smin_next[1] = B_W'(head.item.box.cy) - $signed(B_W'(head.item.box.ey));
                    smax_next[1] = B_W'(head.item.box.cy) + $signed(B_W'(head.item.box.ey));
                    dlt_next[0]  = D_W'(head.item.tx) - D_W'(head.item.box.cx);
                    dlt_next[1]  = D_W'(head.item.ty) - D_W'(head.item.box.cy);
                    vel_next[0]  = N_W'(head.item.tx) - N_W'(head.item.box.cx)
                                   + $signed(N_W'(bias));
                    vel_next[1]  = N_W'(head.item.ty) - N_W'(head.item.box.cy)
                                   - $signed(N_W'(bias));
                    if (head.item.op == sbct_pkg::OP_ADD) begin
                        if (count_reg == CNT_W'(MAX_BOXES)) begin
                            status_next = sbct_pkg::ST_FULL;
                        end else begin
                            ram_we     = 1'b1;
                            ram_waddr  = IDX_W'(count_reg);
                            ram_wdata  = head.item.box;
                            count_next = count_reg + CNT_W'(1);
                        end
                        state_next = sbct_pkg::BK_RESULT;
                    end else if (count_reg == '0) begin
                        if (head.item.op == sbct_pkg::OP_REMOVE) begin
                            status_next = sbct_pkg::ST_NOT_FOUND;
                        end
                        state_next = sbct_pkg::BK_RESULT;
                    end else begin
                        state_next = sbct_pkg::BK_RD;
                    end
                end
            end
            sbct_pkg::BK_RD: begin
                state_next = sbct_pkg::BK_EV;
            end
            sbct_pkg::BK_EV: begin
                state_next = is_end ? sbct_pkg::BK_RESULT : sbct_pkg::BK_RD;
                idx_next   = idx_reg + IDX_W'(1);
                unique case (cur_reg.op)
                    sbct_pkg::OP_REMOVE: begin
                        if (ram_rdata == cur_reg.box) begin
                            found_next = idx_reg;
                            state_next = sbct_pkg::BK_LAST_RD;
                        end else if (is_end) begin
                            status_next = sbct_pkg::ST_NOT_FOUND;
                        end
                    end
                    sbct_pkg::OP_OVERLAP: begin
                        if (ov) begin
                            hit_next   = 1'b1;
                            state_next = sbct_pkg::BK_RESULT;
                        end
                    end
                    sbct_pkg::OP_SWEEP: begin
                        if (ov) begin
                            if (best_reg != '0) begin
                                hit_next    = 1'b1;
                                best_next   = '0;
                                last_next   = '0;
                                normal_next = sbct_pkg::NRM_UP;
                            end
                        end else begin
                            for (int a = 0; a < 2; a++) begin
                                bmin_next[a] = eb_min[a];
                                bmax_next[a] = eb_max[a];
                            end
                            div_start  = 1'b1;
                            idx_next   = idx_reg;
                            state_next = sbct_pkg::BK_DIV;
                        end
                    end
                    default: begin
                        state_next = sbct_pkg::BK_RESULT;
                    end
                endcase
            end
            sbct_pkg::BK_DIV: begin
                if (!div_busy[0] && !div_busy[1]) begin
                    fc_next = T_W'(first_s);
                    lc_next = T_W'(last_s);
                    if ((first_s < $signed(Q_W'(sbct_pkg::ONE_Q16))) && (first_s <= last_s)) begin
                        state_next = sbct_pkg::BK_MUL;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = is_end ? sbct_pkg::BK_RESULT : sbct_pkg::BK_RD;
                    end
                end
            end
            sbct_pkg::BK_MUL: begin
                state_next = sbct_pkg::BK_NORM;
            end
            sbct_pkg::BK_NORM: begin
                if (fc_reg < best_reg) begin
                    hit_next    = 1'b1;
                    best_next   = fc_reg;
                    last_next   = lc_reg;
                    normal_next = nrm;
                end
                idx_next   = idx_reg + IDX_W'(1);
                state_next = is_end ? sbct_pkg::BK_RESULT : sbct_pkg::BK_RD;
            end
            sbct_pkg::BK_LAST_RD: begin
                state_next = sbct_pkg::BK_LAST_EV;
            end
            sbct_pkg::BK_LAST_EV: begin
                ram_we     = 1'b1;
                count_next = count_reg - CNT_W'(1);
                state_next = sbct_pkg::BK_RESULT;
            end
            sbct_pkg::BK_RESULT: begin
                if (out_free) begin
                    out_valid_next             = 1'b1;
                    out_res_next.status        = status_reg;
                    out_res_next.hit           = hit_reg;
                    out_res_next.first_contact = best_reg;
                    out_res_next.last_contact  = last_reg;
                    out_res_next.normal_code   = normal_reg;
                    state_next                 = sbct_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = sbct_pkg::BK_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sbct_pkg::BK_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
        cur_reg     <= cur_next;
        idx_reg     <= idx_next;
        found_reg   <= found_next;
        fc_reg      <= fc_next;
        lc_reg      <= lc_next;
        status_reg  <= status_next;
        hit_reg     <= hit_next;
        best_reg    <= best_next;
        last_reg    <= last_next;
        normal_reg  <= normal_next;
        out_res_reg <= out_res_next;
        for (int a = 0; a < 2; a++) begin
            smin_reg[a] <= smin_next[a];
            smax_reg[a] <= smax_next[a];
            vel_reg[a]  <= vel_next[a];
            dlt_reg[a]  <= dlt_next[a];
            bmin_reg[a] <= bmin_next[a];
            bmax_reg[a] <= bmax_next[a];
            ca_reg[a]   <= ca_next[a];
            cb_reg[a]   <= cb_next[a];
            prod_reg[a] <= prod_next[a];
        end
    end
endmodule
`default_nettype wire

FILE: src/swept_box_collision_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swept_box_collision_table
// Table of static 2d boxes with add, remove, overlap and swept contact
// queries.
//
//   group  direction  contents
//   s_*    in         command in tuser, box and sweep end in tdata
//   m_*    out        status, hit, contact times and normal in tdata
//   cfg_*  in         velocity bias write
//
// add writes one entry; remove and overlap read stored boxes one at a time;
// sweeps also run the 17-step per-axis serial dividers on non-overlapped boxes.
// reset clears the table count and loads a velocity bias of 1.
// two commands queue at the input while one is worked on; a held result
// stalls the engine only once the next result is ready.
// ----------------------------------------------------------------------------
module swept_box_collision_table #(
    parameter int MAX_BOXES = 64
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // command
    input  wire logic [7:0]   s_tuser,
    // center_x, center_y, extent_x, extent_y, target_x, target_y
    input  wire logic [191:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status, hit, first_contact, last_contact, normal_code
    output logic [39:0]       m_tdata,
    input  wire logic         cfg_we,
    input  wire logic [15:0]  cfg_wdata
);
    logic [sbct_pkg::BIAS_W-1:0] bias_reg;
    sbct_pkg::entry_t  in_box;
    sbct_pkg::head_t   head;
    sbct_pkg::result_t res;
    logic              pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_reg <= sbct_pkg::BIAS_W'(1);
        end else if (cfg_we) begin
            bias_reg <= cfg_wdata;
        end
    end

    assign in_box.cx = s_tdata[31:0];
    assign in_box.cy = s_tdata[63:32];
    assign in_box.ex = s_tdata[94:64];
    assign in_box.ey = s_tdata[125:95];

    sbct_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_cmd   (s_tuser[1:0]),
        .in_box   (in_box),
        .in_tx    (s_tdata[157:126]),
        .in_ty    (s_tdata[189:158]),
        .head     (head),
        .pop      (pop)
    );

    sbct_back #(
        .MAX_BOXES (MAX_BOXES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .pop       (pop),
        .bias      (bias_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = res;
endmodule
`default_nettype wire

FILE: src/sbct_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbct_checker
// Port level checks on the result channel of the collision table.
// ----------------------------------------------------------------------------
module sbct_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != 2'd0) |-> !m_tdata[2] && (m_tdata[39:37] == 3'd0))
        else $error("error status with hit or normal");

    a_nohit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[2] |-> (m_tdata[36:20] == 17'd0) && (m_tdata[39:37] == 3'd0))
        else $error("contact data without hit");

    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> (m_tdata[19:3] <= m_tdata[36:20]))
        else $error("first contact after last contact");
endmodule

bind swept_box_collision_table sbct_checker u_sbct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the swept box collision table. Add, remove,
// overlap and sweep commands go in over the input stream; a behavioural
// copy of the box table predicts every result, which is compared field by
// field in arrival order. Both streams idle at random, the receiver holds
// off once for a long stretch, and the velocity bias is swept through its
// extremes between phases.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int TABLE_SIZE = 64;
    localparam int STALL_LIMIT = 40000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tuser;
    logic [191:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [39:0]  m_tdata;
    logic         cfg_we;
    logic [15:0]  cfg_wdata;

    swept_box_collision_table #(.MAX_BOXES(TABLE_SIZE)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // predictor copy of the table
    longint    tbl_cx [TABLE_SIZE];
    longint    tbl_cy [TABLE_SIZE];
    longint    tbl_ex [TABLE_SIZE];
    longint    tbl_ey [TABLE_SIZE];
    int        tbl_count;
    longint    bias_q16;

    sbct_pkg::result_t pending_results[$];
    int        mismatches;
    bit        idling_on;
    int        hold_request;
    int        hold_left = 0;
    int        quiet_cycles = 0;

    function automatic longint div_q16(longint num, longint den);
        longint unsigned an, ad, sc, q, r;
        bit neg;
        an = num < 0 ? -num : num;
        ad = den < 0 ? -den : den;
        sc = an << 16;
        q = sc / ad;
        r = sc % ad;
        neg = (num < 0) != (den < 0);
        if (neg && an != 0) begin
            q += (r != 0);
            if (q > 65536) q = 65536;
            return -longint'(q);
        end
        if (q > 65536) q = 65536;
        return longint'(q);
    endfunction

    function automatic longint floor_q16(longint p);
        longint unsigned m;
        if (p >= 0) return p >>> 16;
        m = -p;
        return -longint'((m + 65535) >> 16);
    endfunction

    function automatic bit box_overlaps(longint cx, longint cy, longint ex, longint ey, int i);
        return cx - ex < tbl_cx[i] + tbl_ex[i] && tbl_cx[i] - tbl_ex[i] < cx + ex &&
               cy - ey < tbl_cy[i] + tbl_ey[i] && tbl_cy[i] - tbl_ey[i] < cy + ey;
    endfunction

    function automatic bit sweep_box(longint from[2], longint to[2], longint ext[2],
                                     longint vel[2], int i, output longint first,
                                     output longint last, output logic [2:0] nrm);
        longint smin[2], smax[2], bmin[2], bmax[2], u0[2], u1[2], cmin[2], cmax[2];
        longint c;
        first = 0;
        last = 0;
        nrm = sbct_pkg::NRM_UP;
        if (box_overlaps(from[0], from[1], ext[0], ext[1], i)) return 1'b1;
        bmin[0] = tbl_cx[i] - tbl_ex[i];
        bmax[0] = tbl_cx[i] + tbl_ex[i];
        bmin[1] = tbl_cy[i] - tbl_ey[i];
        bmax[1] = tbl_cy[i] + tbl_ey[i];
        for (int a = 0; a < 2; a++) begin
            smin[a] = from[a] - ext[a];
            smax[a] = from[a] + ext[a];
            u0[a] = 0;
            u1[a] = 65536;
            if (smax[a] <= bmin[a] && vel[a] > 0) u0[a] = div_q16(bmin[a] - smax[a], vel[a]);
            else if (bmax[a] <= smin[a] && vel[a] < 0)
                u0[a] = div_q16(bmax[a] - smin[a], vel[a]);
            if (bmax[a] <= smin[a] && vel[a] > 0) u1[a] = div_q16(bmax[a] - smin[a], vel[a]);
            else if (smax[a] <= bmin[a] && vel[a] < 0)
                u1[a] = div_q16(bmin[a] - smax[a], vel[a]);
        end
        first = u0[0] > u0[1] ? u0[0] : u0[1];
        last = u1[0] < u1[1] ? u1[0] : u1[1];
        if (!(first < 65536 && first <= last)) return 1'b0;
        for (int a = 0; a < 2; a++) begin
            c = from[a] + floor_q16((to[a] - from[a]) * first);
            cmin[a] = c - ext[a];
            cmax[a] = c + ext[a];
        end
        if (cmax[0] <= bmin[0])
            nrm = cmax[1] < bmin[1] ? sbct_pkg::NRM_LEFT_MINY :
                  (cmin[1] > bmax[1] ? sbct_pkg::NRM_LEFT_PLUSY : sbct_pkg::NRM_LEFT);
        else if (cmin[0] >= bmax[0])
            nrm = cmax[1] < bmin[1] ? sbct_pkg::NRM_RIGHT_MINY :
                  (cmin[1] > bmax[1] ? sbct_pkg::NRM_RIGHT_PLUSY : sbct_pkg::NRM_RIGHT);
        else
            nrm = cmax[1] <= bmin[1] ? sbct_pkg::NRM_UP : sbct_pkg::NRM_DOWN;
        return 1'b1;
    endfunction

    function automatic sbct_pkg::result_t apply_command(sbct_pkg::item_t it);
        sbct_pkg::result_t res;
        longint from[2], to[2], ext[2], vel[2];
        longint best, f, l;
        logic [2:0] n;
        int last_idx;
        res = '0;
        from[0] = it.box.cx; from[1] = it.box.cy;
        to[0] = it.tx; to[1] = it.ty;
        ext[0] = it.box.ex; ext[1] = it.box.ey;
        case (it.op)
            sbct_pkg::OP_ADD: begin
                if (tbl_count >= TABLE_SIZE) res.status = sbct_pkg::ST_FULL;
                else begin
                    tbl_cx[tbl_count] = from[0]; tbl_cy[tbl_count] = from[1];
                    tbl_ex[tbl_count] = ext[0]; tbl_ey[tbl_count] = ext[1];
                    tbl_count++;
                end
            end
            sbct_pkg::OP_REMOVE: begin
                res.status = sbct_pkg::ST_NOT_FOUND;
                for (int i = 0; i < tbl_count; i++) begin
                    if (tbl_cx[i] == from[0] && tbl_cy[i] == from[1] &&
                        tbl_ex[i] == ext[0] && tbl_ey[i] == ext[1]) begin
                        last_idx = tbl_count - 1;
                        tbl_cx[i] = tbl_cx[last_idx]; tbl_cy[i] = tbl_cy[last_idx];
                        tbl_ex[i] = tbl_ex[last_idx]; tbl_ey[i] = tbl_ey[last_idx];
                        tbl_count = last_idx;
                        res.status = sbct_pkg::ST_OK;
                        break;
                    end
                end
            end
            sbct_pkg::OP_OVERLAP: begin
                for (int i = 0; i < tbl_count; i++)
                    if (box_overlaps(from[0], from[1], ext[0], ext[1], i)) begin
                        res.hit = 1'b1;
                        break;
                    end
            end
            default: begin
                vel[0] = to[0] - from[0] + bias_q16;
                vel[1] = to[1] - from[1] - bias_q16;
                best = sbct_pkg::NO_HIT_TIME;
                res.first_contact = sbct_pkg::NO_HIT_TIME;
                for (int i = 0; i < tbl_count; i++) begin
                    if (sweep_box(from, to, ext, vel, i, f, l, n) && f < best) begin
                        best = f;
                        res.hit = 1'b1;
                        res.first_contact = f[sbct_pkg::T_W-1:0];
                        res.last_contact = l[sbct_pkg::T_W-1:0];
                        res.normal_code = n;
                    end
                end
            end
        endcase
        return res;
    endfunction

    task automatic report(string field, longint got, longint want);
        $display("error: %s got %0d expected %0d", field, got, want);
        mismatches++;
    endtask

    task automatic send_command(sbct_pkg::op_t op, logic signed [31:0] cx,
                                logic signed [31:0] cy,
                                logic [30:0] ex, logic [30:0] ey,
                                logic signed [31:0] tx, logic signed [31:0] ty);
        sbct_pkg::item_t it;
        sbct_pkg::result_t expected;
        it.op = op; it.box.cx = cx; it.box.cy = cy; it.box.ex = ex; it.box.ey = ey;
        it.tx = tx; it.ty = ty;
        while (idling_on && $urandom_range(99) < 23) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= {6'd0, op};
        s_tdata <= {2'b00, ty, tx, ey, ex, cy, cx};
        do @(posedge aclk); while (!s_tready);
        expected = apply_command(it);
        pending_results.insert(pending_results.size(), expected);
    endtask

    task automatic drain_and_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_bias(logic [15:0] v);
        drain_and_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        bias_q16 = v;
    endtask

    function automatic logic [31:0] rand_coord(logic [31:0] base);
        case ($urandom_range(9))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: return base + $urandom_range(32'h60000) - 32'h30000;
        endcase
    endfunction

    function automatic logic [30:0] rand_extent();
        case ($urandom_range(9))
            0: return 31'($urandom);
            1: return 31'd0;
            default: return 31'($urandom_range(32'h20000, 32'h800));
        endcase
    endfunction

    task automatic send_random(int add_weight);
        int pick, k;
        logic [31:0] cx, cy;
        pick = $urandom_range(99);
        cx = rand_coord(0);
        cy = rand_coord(0);
        if (pick < add_weight)
            send_command(sbct_pkg::OP_ADD, cx, cy, rand_extent(), rand_extent(), 0, 0);
        else if (pick < add_weight + 15) begin
            if (tbl_count > 0 && $urandom_range(3) != 0) begin
                k = $urandom_range(tbl_count - 1);
                send_command(sbct_pkg::OP_REMOVE, 32'(tbl_cx[k]), 32'(tbl_cy[k]),
                             31'(tbl_ex[k]), 31'(tbl_ey[k]), $urandom, $urandom);
            end else
                send_command(sbct_pkg::OP_REMOVE, cx, cy, rand_extent(), rand_extent(),
                             $urandom, $urandom);
        end else if (pick < add_weight + 40)
            send_command(sbct_pkg::OP_OVERLAP, cx, cy, rand_extent(), rand_extent(),
                         $urandom, $urandom);
        else
            send_command(sbct_pkg::OP_SWEEP, cx, cy, rand_extent(), rand_extent(),
                         rand_coord(cx), rand_coord(cy));
    endtask

    task automatic test_directed();
        send_command(sbct_pkg::OP_SWEEP, 0, 0, 31'h10000, 31'h10000, 32'h40000, 0);
        send_command(sbct_pkg::OP_REMOVE, 0, 0, 31'h10000, 31'h10000, 0, 0);
        send_command(sbct_pkg::OP_ADD, 0, 0, 31'h10000, 31'h10000, 0, 0);
        send_command(sbct_pkg::OP_ADD, 32'h80000000, 32'h7fffffff, 31'h7fffffff, 31'h0,
                     32'hffffffff, 32'hffffffff);
        send_command(sbct_pkg::OP_OVERLAP, 32'h8000, 0, 31'h1000, 31'h1000, 0, 0);
        send_command(sbct_pkg::OP_OVERLAP, 32'h20000, 0, 31'h10000, 31'h10000, 0, 0);
        send_command(sbct_pkg::OP_OVERLAP, 32'h7fffffff, 32'h80000000, 31'h7fffffff,
                     31'h7fffffff, 0, 0);
        send_command(sbct_pkg::OP_SWEEP, -32'h40000, 0, 31'h8000, 31'h8000, 32'h40000, 0);
        send_command(sbct_pkg::OP_SWEEP, 32'h40000, 0, 31'h8000, 31'h8000, -32'h40000, 0);
        send_command(sbct_pkg::OP_SWEEP, 0, -32'h40000, 31'h8000, 31'h8000, 0, 32'h40000);
        send_command(sbct_pkg::OP_SWEEP, 0, 32'h40000, 31'h8000, 31'h8000, 0, -32'h40000);
        send_command(sbct_pkg::OP_SWEEP, -32'h40000, -32'h40000, 31'h8000, 31'h8000,
                     32'h40000, 32'h40000);
        send_command(sbct_pkg::OP_SWEEP, 32'h40000, 32'h40000, 31'h8000, 31'h8000,
                     -32'h40000, -32'h40000);
        send_command(sbct_pkg::OP_SWEEP, 32'h40000, -32'h40000, 31'h8000, 31'h8000,
                     -32'h40000, 32'h40000);
        send_command(sbct_pkg::OP_SWEEP, 0, 0, 31'h100, 31'h100, 32'h40000, 0);
        send_command(sbct_pkg::OP_SWEEP, -32'h40000, 32'h80000, 31'h100, 31'h100,
                     32'h40000, 32'h80000);
        send_command(sbct_pkg::OP_SWEEP, 32'h80000000, 32'h80000000, 31'h7fffffff,
                     31'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_command(sbct_pkg::OP_REMOVE, 32'h80000000, 32'h7fffffff, 31'h7fffffff, 31'h0,
                     0, 0);
        send_command(sbct_pkg::OP_REMOVE, 0, 0, 31'h10000, 31'h10001, 0, 0);
        send_command(sbct_pkg::OP_REMOVE, 0, 0, 31'h10000, 31'h10000, 0, 0);
    endtask

    task automatic test_fill_table();
        while (tbl_count < TABLE_SIZE) send_random(100);
        repeat (5) send_random(100);
        repeat (8) send_random(0);
        while (tbl_count > 4) send_command(sbct_pkg::OP_REMOVE, 32'(tbl_cx[0]),
                                           32'(tbl_cy[0]), 31'(tbl_ex[0]),
                                           31'(tbl_ey[0]), 0, 0);
    endtask

    task automatic test_random_phase(int n, bit with_hold);
        if (with_hold) hold_request = 3000;
        for (int i = 0; i < n; i++) send_random(tbl_count > 40 ? 10 : 35);
    endtask

    task automatic test_no_idle_stretch();
        idling_on = 1'b0;
        for (int i = 0; i < 150; i++) send_random(tbl_count > 40 ? 10 : 35);
        idling_on = 1'b1;
    endtask

    always @(posedge aclk) begin
        sbct_pkg::result_t got, want;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("swept_box_collision_table: mismatch");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_results.size() == 0) begin
                report("unexpected result", got, 0);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) report("status", got.status, want.status);
                if (got.hit !== want.hit) report("hit", got.hit, want.hit);
                if (got.first_contact !== want.first_contact)
                    report("first_contact", got.first_contact, want.first_contact);
                if (got.last_contact !== want.last_contact)
                    report("last_contact", got.last_contact, want.last_contact);
                if (got.normal_code !== want.normal_code)
                    report("normal_code", got.normal_code, want.normal_code);
            end
        end
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else
            m_tready <= !(idling_on && $urandom_range(99) < 23);
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        tbl_count = 0;
        bias_q16 = 1;
        mismatches = 0;
        idling_on = 1'b1;
        hold_request = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        write_bias(16'd0);
        test_directed();
        test_fill_table();
        write_bias(16'hffff);
        test_random_phase(350, 1'b1);
        write_bias(16'd1);
        test_no_idle_stretch();
        test_random_phase(200, 1'b0);
        write_bias(16'($urandom));
        test_random_phase(350, 1'b0);
        write_bias(16'($urandom));
        test_random_phase(350, 1'b0);
        write_bias(16'd0);
        test_random_phase(250, 1'b0);

        drain_and_idle();
        if (mismatches == 0)
            $display("swept_box_collision_table: match");
        else
            $display("swept_box_collision_table: mismatch");
        $finish;
    end
endmodule
